/* rtl/core/smt_pkg.sv */
// ----------------------------------------------------------------------------
// smt_pkg: shared types and constants of the sparse matrix transposer
// Field widths, stream packing, item and result structures.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int RowW      = 10;
  localparam int ValW      = 64;
  localparam int DimW      = 11;
  localparam int DefMaxDim = 1024;
  localparam int DefMaxNnz = 4096;

  localparam logic [DimW-1:0] DimReset = 11'd1024;

  localparam int ItemBits = 2 * RowW + 2 * ValW;
  localparam int TdataW   = ((ItemBits + 7) / 8) * 8;
  localparam int PadW     = TdataW - ItemBits;

  typedef enum logic {
    ModeLoad  = 1'b0,
    ModeFetch = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e           mode;
    logic [RowW-1:0] src_row;
    logic [RowW-1:0] src_col;
    logic [ValW-1:0] in_val_re;
    logic [ValW-1:0] in_val_im;
  } item_t;

  typedef struct packed {
    logic [RowW-1:0] out_row;
    logic [RowW-1:0] out_col;
    logic [ValW-1:0] out_val_re;
    logic [ValW-1:0] out_val_im;
    logic            last;
    logic            empty_res;
  } res_t;

endpackage

/* rtl/core/smt_ram.sv */
// ----------------------------------------------------------------------------
// smt_ram: generic single-clock RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module smt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/smt_core.sv */
// ----------------------------------------------------------------------------
// smt_core: column chaining and transposed read-out
// Holds the column table, the link table and the entry store in RAMs and
// sequences loads, column scans and fetches over them.
// ----------------------------------------------------------------------------
module smt_core #(
  parameter int MaxDim = 1024,
  parameter int MaxNnz = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [$clog2(MaxDim):0]   eff_dim_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  smt_pkg::item_t            in_item_i,
  input  logic                      out_free_i,
  output logic                      res_valid_o,
  output smt_pkg::res_t             res_o
);
  import smt_pkg::*;

  localparam int ColAw    = $clog2(MaxDim);
  localparam int ScW      = ColAw + 1;
  localparam int PtrW     = $clog2(MaxNnz);
  localparam int CntW     = PtrW + 1;
  localparam int ColWordW = 1 + 2 * PtrW;
  localparam int DataW    = RowW + 2 * ValW;

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StLdChk = 7'b0000100,
    StLdUpd = 7'b0001000,
    StSeek  = 7'b0010000,
    StFChk  = 7'b0100000,
    StFOut  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  item_t            item_q, item_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  emit_q, emit_d;
  logic [ScW-1:0]   scan_col_q, scan_col_d;
  logic [PtrW-1:0]  scan_ptr_q, scan_ptr_d;
  logic             reading_q, reading_d;
  logic [ColAw-1:0] clr_addr_q, clr_addr_d;
  logic             clr_to_ld_q, clr_to_ld_d;
  logic [ScW-1:0]   seek_col_q, seek_col_d;
  logic             pend_q, pend_d;
  logic             seek_to_fetch_q, seek_to_fetch_d;

  logic                col_we, col_re;
  logic [ColAw-1:0]    col_waddr, col_raddr;
  logic [ColWordW-1:0] col_wdata, col_rdata;
  logic                link_we, link_re;
  logic [PtrW-1:0]     link_waddr, link_raddr;
  logic [PtrW-1:0]     link_wdata, link_rdata;
  logic                data_we, data_re;
  logic [PtrW-1:0]     data_waddr, data_raddr;
  logic [DataW-1:0]    data_wdata, data_rdata;

  logic             col_used;
  logic [PtrW-1:0]  col_head, col_tail;
  logic [31:0]      eff32, ld_col32, scan_col32, seek_col32;
  logic [ColAw-1:0] ld_col_addr;
  logic [PtrW-1:0]  slot;
  logic             ld_full, ld_col_ok;
  logic             res_valid;
  res_t             res;

  assign col_used    = col_rdata[ColWordW-1];
  assign col_head    = col_rdata[2*PtrW-1:PtrW];
  assign col_tail    = col_rdata[PtrW-1:0];
  assign eff32       = 32'(eff_dim_i);
  assign ld_col32    = 32'(item_q.src_col);
  assign scan_col32  = 32'(scan_col_q);
  assign seek_col32  = 32'(seek_col_q);
  assign ld_col_addr = ld_col32[ColAw-1:0];
  assign slot        = count_q[PtrW-1:0];
  assign ld_full     = (count_q == CntW'(MaxNnz));
  assign ld_col_ok   = (ld_col32 < eff32);
  assign in_ready_o  = (state_q == StIdle);

  always_comb begin
    state_d         = state_q;
    item_d          = item_q;
    count_d         = count_q;
    emit_d          = emit_q;
    scan_col_d      = scan_col_q;
    scan_ptr_d      = scan_ptr_q;
    reading_d       = reading_q;
    clr_addr_d      = clr_addr_q;
    clr_to_ld_d     = clr_to_ld_q;
    seek_col_d      = seek_col_q;
    pend_d          = pend_q;
    seek_to_fetch_d = seek_to_fetch_q;
    col_we          = 1'b0;
    col_waddr       = '0;
    col_wdata       = '0;
    col_re          = 1'b0;
    col_raddr       = '0;
    link_we         = 1'b0;
    link_waddr      = '0;
    link_wdata      = '0;
    link_re         = 1'b0;
    link_raddr      = '0;
    data_we         = 1'b0;
    data_waddr      = '0;
    data_wdata      = '0;
    data_re         = 1'b0;
    data_raddr      = '0;
    res_valid       = 1'b0;
    res             = '0;

    case (state_q)
      StClear: begin
        col_we    = 1'b1;
        col_waddr = clr_addr_q;
        if (clr_addr_q == ColAw'(MaxDim - 1)) begin
          clr_addr_d = '0;
          state_d    = clr_to_ld_q ? StLdChk : StIdle;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          item_d = in_item_i;
          if (in_item_i.mode == ModeLoad) begin
            if (reading_q) begin
              count_d     = '0;
              emit_d      = '0;
              scan_col_d  = '0;
              scan_ptr_d  = '0;
              reading_d   = 1'b0;
              clr_to_ld_d = 1'b1;
              state_d     = StClear;
            end else begin
              state_d = StLdChk;
            end
          end else if (!reading_q) begin
            reading_d       = 1'b1;
            emit_d          = '0;
            seek_col_d      = '0;
            pend_d          = 1'b0;
            seek_to_fetch_d = 1'b1;
            state_d         = StSeek;
          end else begin
            state_d = StFChk;
          end
        end
      end
      StLdChk: begin
        if (ld_full || !ld_col_ok) begin
          state_d = StIdle;
        end else begin
          col_re     = 1'b1;
          col_raddr  = ld_col_addr;
          data_we    = 1'b1;
          data_waddr = slot;
          data_wdata = {item_q.src_row, item_q.in_val_re, item_q.in_val_im};
          state_d    = StLdUpd;
        end
      end
      StLdUpd: begin
        col_we    = 1'b1;
        col_waddr = ld_col_addr;
        if (col_used) begin
          link_we    = 1'b1;
          link_waddr = col_tail;
          link_wdata = slot;
          col_wdata  = {1'b1, col_head, slot};
        end else begin
          col_wdata  = {1'b1, slot, slot};
        end
        count_d = count_q + 1'b1;
        state_d = StIdle;
      end
      StSeek: begin
        if (pend_q && col_used) begin
          scan_col_d = seek_col_q - 1'b1;
          scan_ptr_d = col_head;
          pend_d     = 1'b0;
          state_d    = seek_to_fetch_q ? StFChk : StIdle;
        end else if (seek_col32 >= eff32) begin
          scan_col_d = seek_col_q;
          pend_d     = 1'b0;
          state_d    = seek_to_fetch_q ? StFChk : StIdle;
        end else begin
          col_re     = 1'b1;
          col_raddr  = seek_col_q[ColAw-1:0];
          pend_d     = 1'b1;
          seek_col_d = seek_col_q + 1'b1;
        end
      end
      StFChk: begin
        if (emit_q >= count_q || scan_col32 >= eff32) begin
          if (out_free_i) begin
            res_valid     = 1'b1;
            res.empty_res = 1'b1;
            state_d       = StIdle;
          end
        end else begin
          col_re     = 1'b1;
          col_raddr  = scan_col_q[ColAw-1:0];
          link_re    = 1'b1;
          link_raddr = scan_ptr_q;
          data_re    = 1'b1;
          data_raddr = scan_ptr_q;
          state_d    = StFOut;
        end
      end
      StFOut: begin
        if (out_free_i) begin
          res_valid = 1'b1;
          state_d   = StIdle;
          if (!col_used) begin
            res.empty_res = 1'b1;
          end else begin
            res.out_row    = scan_col32[RowW-1:0];
            res.out_col    = data_rdata[DataW-1 -: RowW];
            res.out_val_re = data_rdata[2*ValW-1:ValW];
            res.out_val_im = data_rdata[ValW-1:0];
            res.last       = ((emit_q + 1'b1) == count_q);
            emit_d         = emit_q + 1'b1;
            if (scan_ptr_q == col_tail) begin
              seek_col_d      = scan_col_q + 1'b1;
              pend_d          = 1'b0;
              seek_to_fetch_d = 1'b0;
              state_d         = StSeek;
            end else begin
              scan_ptr_d = link_rdata;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StClear;
      count_q         <= '0;
      emit_q          <= '0;
      scan_col_q      <= '0;
      scan_ptr_q      <= '0;
      reading_q       <= 1'b0;
      clr_addr_q      <= '0;
      clr_to_ld_q     <= 1'b0;
      seek_col_q      <= '0;
      pend_q          <= 1'b0;
      seek_to_fetch_q <= 1'b0;
    end else begin
      state_q         <= state_d;
      count_q         <= count_d;
      emit_q          <= emit_d;
      scan_col_q      <= scan_col_d;
      scan_ptr_q      <= scan_ptr_d;
      reading_q       <= reading_d;
      clr_addr_q      <= clr_addr_d;
      clr_to_ld_q     <= clr_to_ld_d;
      seek_col_q      <= seek_col_d;
      pend_q          <= pend_d;
      seek_to_fetch_q <= seek_to_fetch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  smt_ram #(
    .Width(ColWordW),
    .Depth(MaxDim)
  ) u_col_ram (
    .clk_i  (clk_i),
    .we_i   (col_we),
    .waddr_i(col_waddr),
    .wdata_i(col_wdata),
    .re_i   (col_re),
    .raddr_i(col_raddr),
    .rdata_o(col_rdata)
  );

  smt_ram #(
    .Width(PtrW),
    .Depth(MaxNnz)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .re_i   (link_re),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  smt_ram #(
    .Width(DataW),
    .Depth(MaxNnz)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (data_we),
    .waddr_i(data_waddr),
    .wdata_i(data_wdata),
    .re_i   (data_re),
    .raddr_i(data_raddr),
    .rdata_o(data_rdata)
  );

  assign res_valid_o = res_valid;
  assign res_o       = res;

  a_emit_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q <= count_q)
    else $error("More entries emitted than loaded.");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxNnz))
    else $error("Entry count beyond capacity.");

  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !reading_q |-> emit_q == '0)
    else $error("Emitted count set outside the read-out phase.");

  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free_i)
    else $error("Result produced while the output register is occupied.");

  a_load_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLdUpd |=> count_q == $past(count_q) + 1'b1)
    else $error("Stored load did not advance the entry count.");

endmodule

/* rtl/core/sparse_matrix_transpose.sv */
// ----------------------------------------------------------------------------
// sparse_matrix_transpose: transposer for a square sparse matrix
// Nonzeros are loaded in stored order and chained per column; fetches
// return them by ascending column, in load order within a column.
//
//   Channel  Dir  Handshake                 Contents
//   s_axis   in   s_axis_tvalid/tready      load or fetch item
//   m_axis   out  m_axis_tvalid/tready      one transposed entry per fetch
//   cfg      in   cfg_we_i                  matrix dimension
//
// A load passes through acceptance, column table read and write-back, or ends
// at the check if dropped; a fetch through acceptance, table reads and output,
// or ends at the check if it answers empty. A finished column, and the first
// fetch, start a scan of the column table one column at a time through its
// single read port. After reset, and before a load following fetching, the
// column table is cleared over all MAX_DIM entries while no item is accepted.
// Results wait in an output register; a fetch stalls only if full and unread.
// ----------------------------------------------------------------------------
module sparse_matrix_transpose #(
  parameter int MAX_DIM = smt_pkg::DefMaxDim,
  parameter int MAX_NNZ = smt_pkg::DefMaxNnz
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [smt_pkg::DimW-1:0]    cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // src_row, src_col, in_val_re, in_val_im, zero pad
  input  logic [smt_pkg::TdataW-1:0]  s_axis_tdata,
  // mode
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_row, out_col, out_val_re, out_val_im, zero pad
  output logic [smt_pkg::TdataW-1:0]  m_axis_tdata,
  // empty_res
  output logic                        m_axis_tuser,
  output logic                        m_axis_tlast
);
  import smt_pkg::*;

  localparam int ScW = $clog2(MAX_DIM) + 1;

  logic [DimW-1:0] dim_q;
  logic [31:0]     dim32;
  logic [ScW-1:0]  eff_dim;
  item_t           in_item;
  logic            out_valid_q, out_valid_d;
  res_t            out_res_q, out_res_d;
  logic            out_free;
  logic            res_valid;
  res_t            res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DimReset;
    end else if (cfg_we_i) begin
      dim_q <= cfg_wdata_i;
    end
  end

  assign dim32   = 32'(dim_q);
  assign eff_dim = (dim32 > 32'(MAX_DIM)) ? ScW'(MAX_DIM) : ScW'(dim32);

  assign in_item.mode      = mode_e'(s_axis_tuser);
  assign in_item.src_row   = s_axis_tdata[RowW-1:0];
  assign in_item.src_col   = s_axis_tdata[2*RowW-1:RowW];
  assign in_item.in_val_re = s_axis_tdata[2*RowW+ValW-1:2*RowW];
  assign in_item.in_val_im = s_axis_tdata[ItemBits-1:2*RowW+ValW];

  assign out_free = !out_valid_q || m_axis_tready;

  smt_core #(
    .MaxDim(MAX_DIM),
    .MaxNnz(MAX_NNZ)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .eff_dim_i  (eff_dim),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .out_free_i (out_free),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_res_q.out_val_im, out_res_q.out_val_re,
                          out_res_q.out_col, out_res_q.out_row};
  assign m_axis_tuser  = out_res_q.empty_res;
  assign m_axis_tlast  = out_res_q.last;

endmodule
